/* design/assert_macros.svh */
// Assertion macros used by the depth test top level.
// Plain property wrappers, clocked on the caller's clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check under synchronous reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/nfdt_pkg.sv */
// Package for the nearest face depth test: widths, slots, constants.
// No dependencies.
`timescale 1ns / 1ps
package nfdt_pkg;
    localparam int FACES_DEF = 4;
    localparam int WORDS_PER_FACE = 10;
    localparam int DEPTH_W = 48;
    localparam logic signed [DEPTH_W-1:0] FAR_RESET = 48'sd6553600;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 48'sh8000_0000_0000;
    localparam logic [0:0] OP_WRITE = 1'b0;
    localparam logic [0:0] OP_QUERY = 1'b1;
    localparam logic [3:0] SLOT_C = 4'd8;
    localparam logic [3:0] SLOT_LAST = 4'd9;
    localparam logic [3:0] VERTEX_SLOTS = 4'd6;
    localparam int DIV_NUM_W = 66; // |num| < 2^50, shifted by 16
    localparam int DIV_DEN_W = 33;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;
endpackage

/* design/nfdt_ram.sv */
// Generic simple dual port RAM (one write port, one read port), registered read.
// No dependencies.
`timescale 1ns / 1ps
module nfdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/nfdt_div.sv */
// Restoring divider, one quotient bit per cycle, signed result saturated to 48 bits.
// Depends on nfdt_pkg.
`timescale 1ns / 1ps
module nfdt_div
    import nfdt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_div_req                  i_req,
    output logic                      o_done,
    output logic signed [DEPTH_W-1:0] o_quot
);
    localparam int CW = $clog2(DIV_NUM_W + 1);
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic                 r_neg, r_busy;
    logic [CW-1:0]        r_cnt;
    logic [DIV_DEN_W:0]   w_sh;
    logic [DIV_DEN_W:0]   w_sub;
    always_comb begin
        w_sh  = {r_rem[DIV_DEN_W-1:0], r_q[DIV_NUM_W-1]};
        w_sub = w_sh - {1'b0, r_den};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_neg  <= i_req.neg;
                r_rem  <= '0;
                r_cnt  <= CW'(DIV_NUM_W);
            end else if (r_busy) begin
                if (!w_sub[DIV_DEN_W]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[DIV_NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    always_comb begin
        if (r_neg) begin
            if (r_q[DIV_NUM_W-1:DEPTH_W-1] != '0) o_quot = DEPTH_MIN;
            else o_quot = -$signed(r_q[DEPTH_W-1:0]);
        end else begin
            if (r_q[DIV_NUM_W-1:DEPTH_W-1] != '0) o_quot = DEPTH_MAX;
            else o_quot = $signed(r_q[DEPTH_W-1:0]);
        end
    end
endmodule

/* design/nearest_face_depth_test_top.sv */
// Top level: face store, clear sweep, sequencer with one shared multiplier.
// Depends on nfdt_pkg, nfdt_ram, nfdt_div, assert_macros.svh.
// Query time is set by the per-face word reads, serial multiplies and the bit-serial
// divider of 66 steps; a write is stored as it is accepted.
// A face with C zero or a point outside its triangle skips the divide.
// Throughput: one word at a time, ready low while a query or the clear runs.
// Reset: synchronous; then a clear sweep zeroes all FACES*10 words of the store.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nearest_face_depth_test_top
    import nfdt_pkg::*;
#(
    parameter int FACES = FACES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_opcode,
    input  logic [1:0]                i_face_index,
    input  logic [3:0]                i_word_slot,
    input  logic signed [31:0]        i_word_value,
    input  logic signed [15:0]        i_point_x,
    input  logic signed [15:0]        i_point_y,
    input  logic                      i_cfg_we,
    input  logic signed [DEPTH_W-1:0] i_cfg_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_hit,
    output logic [1:0]                o_nearest_face,
    output logic signed [DEPTH_W-1:0] o_nearest_depth
);
    localparam int DEPTH = FACES * WORDS_PER_FACE;
    localparam int AW = $clog2(DEPTH);
    localparam int FW = (FACES > 1) ? $clog2(FACES) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_MUL, S_EDGE, S_NUM, S_DIVS, S_DIVW, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_addr;
    logic [FW-1:0] r_face;
    logic [3:0]    r_slot;
    logic          r_rvalid;
    logic [3:0]    r_rslot;
    logic signed [31:0] r_w [WORDS_PER_FACE];
    logic signed [15:0] r_px, r_py;
    logic signed [DEPTH_W-1:0] r_far, r_best;
    logic [FW-1:0] r_best_face;
    logic          r_hit;
    logic [3:0]    r_mstep;
    logic signed [67:0] r_prod;
    logic signed [51:0] r_acc;
    logic signed [35:0] r_cr [6];
    logic          r_mval;
    logic [3:0]    r_mdst;
    t_div_req      r_dreq;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata;
    logic          w_div_done;
    logic signed [DEPTH_W-1:0] w_quot;
    logic signed [31:0] w_sat;
    logic          w_acc_in, w_wr_ok, w_cov;
    logic signed [33:0] w_ma, w_mb;
    logic signed [16:0] w_oa, w_ob;
    logic signed [16:0] ax, ay, bx, by, cx, cy, px, py;

    assign o_ready  = (r_state == S_IDLE);
    assign w_acc_in = i_valid && o_ready;
    assign w_wr_ok  = (32'(i_face_index) < 32'(FACES)) && (i_word_slot <= SLOT_LAST);

    always_comb begin
        if (i_word_slot < VERTEX_SLOTS) begin
            if (i_word_value > 32'sd32767) w_sat = 32'sd32767;
            else if (i_word_value < -32'sd32768) w_sat = -32'sd32768;
            else w_sat = i_word_value;
        end else begin
            w_sat = i_word_value;
        end
    end

    assign w_we    = (r_state == S_CLEAR) || (w_acc_in && i_opcode == OP_WRITE && w_wr_ok);
    assign w_waddr = (r_state == S_CLEAR) ? r_addr
                   : AW'(32'(i_face_index) * WORDS_PER_FACE + 32'(i_word_slot));
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_sat;
    assign w_raddr = r_addr;

    nfdt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    nfdt_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_dreq),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    // vertices and point widened by one bit for the differences
    always_comb begin
        ax = {r_w[0][15], r_w[0][15:0]}; ay = {r_w[1][15], r_w[1][15:0]};
        bx = {r_w[2][15], r_w[2][15:0]}; by = {r_w[3][15], r_w[3][15:0]};
        cx = {r_w[4][15], r_w[4][15:0]}; cy = {r_w[5][15], r_w[5][15:0]};
        px = {r_px[15], r_px}; py = {r_py[15], r_py};
        w_oa = '0; w_ob = '0;
    end

    // sign product per edge: cr[2e] third vertex, cr[2e+1] point
    function automatic logic opp(input logic signed [35:0] a, input logic signed [35:0] b);
        opp = (a > 0 && b < 0) || (a < 0 && b > 0);
    endfunction
    assign w_cov = !opp(r_cr[0], r_cr[1]) && !opp(r_cr[2], r_cr[3]) && !opp(r_cr[4], r_cr[5]);

    // multiply schedule: 12 products for edges (cross = p0 - p1), then A*x, B*y
    always_comb begin
        w_ma = '0; w_mb = '0;
        case (r_mstep)
            4'd0:  begin w_ma = 34'(bx - ax); w_mb = 34'(cy - ay); end
            4'd1:  begin w_ma = 34'(by - ay); w_mb = 34'(cx - ax); end
            4'd2:  begin w_ma = 34'(bx - ax); w_mb = 34'(py - ay); end
            4'd3:  begin w_ma = 34'(by - ay); w_mb = 34'(px - ax); end
            4'd4:  begin w_ma = 34'(cx - ax); w_mb = 34'(by - ay); end
            4'd5:  begin w_ma = 34'(cy - ay); w_mb = 34'(bx - ax); end
            4'd6:  begin w_ma = 34'(cx - ax); w_mb = 34'(py - ay); end
            4'd7:  begin w_ma = 34'(cy - ay); w_mb = 34'(px - ax); end
            4'd8:  begin w_ma = 34'(bx - cx); w_mb = 34'(ay - cy); end
            4'd9:  begin w_ma = 34'(by - cy); w_mb = 34'(ax - cx); end
            4'd10: begin w_ma = 34'(bx - cx); w_mb = 34'(py - cy); end
            4'd11: begin w_ma = 34'(by - cy); w_mb = 34'(px - cx); end
            4'd12: begin w_ma = 34'(r_w[6]); w_mb = 34'(r_px); end
            4'd13: begin w_ma = 34'(r_w[7]); w_mb = 34'(r_py); end
            default: begin w_ma = '0; w_mb = 34'(w_ob + w_oa); end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_far    <= FAR_RESET;
            o_valid  <= 1'b0;
            r_rvalid <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            if (i_cfg_we) r_far <= i_cfg_data;
            r_rvalid     <= 1'b0;
            r_dreq.start <= 1'b0;
            if (r_rvalid) r_w[r_rslot] <= w_rdata;
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (32'(r_addr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc_in && i_opcode == OP_QUERY) begin
                        r_px <= i_point_x; r_py <= i_point_y;
                        r_best <= r_far; r_hit <= 1'b0; r_best_face <= '0;
                        r_face <= '0; r_addr <= '0; r_slot <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rvalid <= 1'b1;
                    r_rslot  <= r_slot;
                    if (r_slot == SLOT_LAST) begin
                        r_slot  <= '0;
                        r_mstep <= '0;
                        r_mval  <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_MUL: begin
                    // wait until the last word is stored, then skip C == 0
                    if (!r_mval && !r_rvalid && r_mstep == 4'd0 && r_w[SLOT_C] == '0) begin
                        r_state <= S_NEXT;
                    end else if (!r_rvalid) begin
                        r_prod <= w_ma * w_mb;
                        r_mval <= 1'b1;
                        r_mdst <= r_mstep;
                        if (r_mval) begin
                            if (r_mdst[0] == 1'b0) r_acc <= 52'(r_prod);
                            else if (r_mdst < 4'd12) r_cr[r_mdst[3:1]] <= 36'(r_acc - 52'(r_prod));
                            else r_acc <= r_acc + 52'(r_prod);
                        end
                        r_mstep <= r_mstep + 1'b1;
                        if (r_mstep == 4'd14) r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (!w_cov) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_acc <= r_acc + 52'(r_w[9]);
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_dreq.start <= 1'b1;
                    r_dreq.num <= {(r_acc < 0) ? 50'(-r_acc) : 50'(r_acc), 16'd0};
                    r_dreq.den <= (r_w[SLOT_C] < 0) ? 33'(-33'(r_w[SLOT_C]))
                                                   : 33'(r_w[SLOT_C]);
                    r_dreq.neg <= (r_acc != 0) && ((r_acc < 0) != (r_w[SLOT_C] > 0));
                    r_state <= S_DIVS;
                end
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_div_done) begin
                        if (w_quot < r_best) begin
                            r_best <= w_quot; r_best_face <= r_face; r_hit <= 1'b1;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (32'(r_face) == FACES - 1) begin
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_face  <= r_face + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_hit           = r_hit;
    assign o_nearest_face  = 2'(r_best_face);
    assign o_nearest_depth = r_best;

    `ASSERT_IMP(a_out_only_in_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `ASSERT_IMP(a_face_when_miss, i_clk, i_rst_n, o_valid && !o_hit, o_nearest_face == 2'd0)
    `ASSERT_NXT(a_done_leaves_out, i_clk, i_rst_n, o_valid && i_ready, !o_valid)
endmodule

/* tb/sv/nearest_face_depth_test_checker.sv */
// Checker for the nearest face depth test: mirrors the face store and far limit,
// predicts each query answer and compares it with the result words. Uses nfdt_pkg.
`timescale 1ns / 1ps
module nearest_face_depth_test_checker
    import nfdt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_ready_in,
    input  logic                      i_opcode,
    input  logic [1:0]                i_face_index,
    input  logic [3:0]                i_word_slot,
    input  logic signed [31:0]        i_word_value,
    input  logic signed [15:0]        i_point_x,
    input  logic signed [15:0]        i_point_y,
    input  logic                      i_cfg_we,
    input  logic signed [DEPTH_W-1:0] i_cfg_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_hit,
    input  logic [1:0]                i_nearest_face,
    input  logic signed [DEPTH_W-1:0] i_nearest_depth,
    output int                        o_errors,
    output int                        o_pending
);
    typedef struct packed {
        logic                      hit;
        logic [1:0]                face;
        logic signed [DEPTH_W-1:0] depth;
    } t_answer;

    logic signed [31:0]        face_mem [FACES_DEF*WORDS_PER_FACE];
    logic signed [DEPTH_W-1:0] far_limit;
    t_answer                   answer_q [$];

    function automatic int sgn(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic int side_of(longint ax, longint ay, longint bx, longint by,
                                   longint px, longint py);
        return sgn((bx - ax) * (py - ay) - (by - ay) * (px - ax));
    endfunction

    function automatic bit edge_agrees(longint ax, longint ay, longint bx, longint by,
                                       longint ox, longint oy, longint px, longint py);
        return side_of(ax, ay, bx, by, ox, oy) * side_of(ax, ay, bx, by, px, py) >= 0;
    endfunction

    function automatic logic signed [DEPTH_W-1:0] face_depth(int f, longint x, longint y);
        longint a, b, c, d, num;
        logic [65:0] mag, cm, q;
        bit neg;
        a = face_mem[f*WORDS_PER_FACE+6];
        b = face_mem[f*WORDS_PER_FACE+7];
        c = face_mem[f*WORDS_PER_FACE+8];
        d = face_mem[f*WORDS_PER_FACE+9];
        num = a * x + b * y + d;
        mag = (num < 0) ? 66'(-num) : 66'(num);
        cm = (c < 0) ? 66'(-c) : 66'(c);
        q = (mag << 16) / cm;
        neg = ((num < 0) != (c > 0)) && num != 0;
        if (neg) begin
            if (q >= 66'h8000_0000_0000) return DEPTH_MIN;
            return -$signed(DEPTH_W'(q));
        end
        if (q > 66'h7FFF_FFFF_FFFF) return DEPTH_MAX;
        return DEPTH_W'(q);
    endfunction

    function automatic t_answer nearest_answer(longint px, longint py);
        t_answer r;
        longint ax, ay, bx, by, cx, cy;
        logic signed [DEPTH_W-1:0] z;
        int base;
        r.hit = 1'b0;
        r.face = 2'd0;
        r.depth = far_limit;
        for (int f = 0; f < FACES_DEF; f++) begin
            base = f * WORDS_PER_FACE;
            if (face_mem[base+SLOT_C] == 0) continue;
            ax = face_mem[base];   ay = face_mem[base+1];
            bx = face_mem[base+2]; by = face_mem[base+3];
            cx = face_mem[base+4]; cy = face_mem[base+5];
            if (!(edge_agrees(ax, ay, bx, by, cx, cy, px, py)
                  && edge_agrees(ax, ay, cx, cy, bx, by, px, py)
                  && edge_agrees(cx, cy, bx, by, ax, ay, px, py))) continue;
            z = face_depth(f, px, py);
            if (z < r.depth) begin
                r.hit = 1'b1;
                r.face = 2'(f);
                r.depth = z;
            end
        end
        return r;
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        t_answer want, got;
        logic signed [31:0] v;
        if (!i_rst_n) begin
            foreach (face_mem[k]) face_mem[k] <= '0;
            far_limit <= FAR_RESET;
            answer_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) far_limit <= i_cfg_data;
            if (i_valid && i_ready_in) begin
                if (i_opcode == OP_QUERY) begin
                    answer_q.push_back(nearest_answer(i_point_x, i_point_y));
                end else if (i_word_slot <= SLOT_LAST && i_face_index < FACES_DEF) begin
                    v = i_word_value;
                    if (i_word_slot < VERTEX_SLOTS) begin
                        if (v > 32767) v = 32767;
                        if (v < -32768) v = -32768;
                    end
                    face_mem[i_face_index*WORDS_PER_FACE + i_word_slot] <= v;
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_hit, i_nearest_face, i_nearest_depth};
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result word hit=%0b face=%0d depth=%0d",
                             $time, got.hit, got.face, got.depth);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected hit=%0b face=%0d depth=%0d",
                                 $time, want.hit, want.face, want.depth);
                        $display("%0t:          actual   hit=%0b face=%0d depth=%0d",
                                 $time, got.hit, got.face, got.depth);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/nearest_face_depth_test_top_tb.sv */
// Testbench top for the nearest face depth test: clock, reset, face loads,
// queries and far-limit phases. Depends on nfdt_pkg, the top module and the checker module.
`timescale 1ns / 1ps
module nearest_face_depth_test_top_tb;
    import nfdt_pkg::*;

    localparam int WATCHDOG = 200000;

    logic                      clk, rst_n;
    logic                      in_valid, in_ready;
    logic                      opcode;
    logic [1:0]                face_index;
    logic [3:0]                word_slot;
    logic signed [31:0]        word_value;
    logic signed [15:0]        point_x, point_y;
    logic                      cfg_we;
    logic signed [DEPTH_W-1:0] cfg_data;
    logic                      out_valid, out_ready;
    logic                      hit;
    logic [1:0]                nearest_face;
    logic signed [DEPTH_W-1:0] nearest_depth;
    int                        errors, pending, idle_cycles;
    bit                        calm;

    nearest_face_depth_test_top u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_opcode(opcode), .i_face_index(face_index), .i_word_slot(word_slot),
        .i_word_value(word_value), .i_point_x(point_x), .i_point_y(point_y),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data), .o_valid(out_valid),
        .i_ready(out_ready), .o_hit(hit), .o_nearest_face(nearest_face),
        .o_nearest_depth(nearest_depth)
    );

    nearest_face_depth_test_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_opcode(opcode), .i_face_index(face_index), .i_word_slot(word_slot),
        .i_word_value(word_value), .i_point_x(point_x), .i_point_y(point_y),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_hit(hit), .i_nearest_face(nearest_face),
        .i_nearest_depth(nearest_depth), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stalls in bursts
    initial begin
        int n;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one word on the input channel; called just after a falling edge.
    // valid stays up after the word is taken; idling or drain drops it.
    task automatic send_word(logic op, logic [1:0] f, logic [3:0] s,
                             logic signed [31:0] v, logic signed [15:0] x,
                             logic signed [15:0] y);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        face_index <= f;
        word_slot <= s;
        word_value <= v;
        point_x <= x;
        point_y <= y;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic load_face(logic [1:0] f, logic signed [31:0] w [10]);
        for (int s = 0; s < 10; s++) send_word(OP_WRITE, f, 4'(s), w[s], 0, 0);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_far(logic signed [DEPTH_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rnd_coord(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_face(logic [1:0] f);
        logic signed [31:0] w [10];
        int span;
        span = ($urandom_range(0, 7) == 0) ? 32767 : 200;
        for (int s = 0; s < 6; s++) w[s] = rnd_coord(span);
        for (int s = 6; s < 10; s++) w[s] = $signed($urandom_range(0, 400)) - 200;
        if ($urandom_range(0, 7) == 0) w[$urandom_range(6, 9)] = $urandom;
        if ($urandom_range(0, 9) == 0) w[SLOT_C] = 0;
        if ($urandom_range(0, 9) == 0) begin
            w[0] = $urandom; w[1] = $urandom;
        end
        load_face(f, w);
    endtask

    initial begin
        logic signed [31:0] w [10];
        int items;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_WRITE;
        face_index = '0;
        word_slot = '0;
        word_value = '0;
        point_x = '0;
        point_y = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store: every C is zero, no face counts
        send_word(OP_QUERY, 0, 0, 0, 16'sh7FFF, 16'sh8000);
        // face 0 plain triangle, face 1 same area at equal depth: a tie, which face 0 keeps
        w = '{0, 0, 100, 0, 0, 100, 0, 0, 1, -5};
        load_face(0, w);
        w = '{0, 0, 100, 0, 0, 100, 0, 0, -1, 5};
        load_face(1, w);
        send_word(OP_QUERY, 0, 0, 0, 10, 10);
        send_word(OP_QUERY, 0, 0, 0, 100, 0);
        send_word(OP_QUERY, 0, 0, 0, 60, 60);
        // collinear face covers all; saturating vertex writes; huge plane
        w = '{32'sh7FFF_FFFF, 32'sh8000_0000, 5, 5, 9, 9,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF};
        load_face(2, w);
        w = '{1, 1, 2, 2, 3, 3, 32'sh8000_0000, 32'sh8000_0000, 1, 32'sh8000_0000};
        load_face(3, w);
        send_word(OP_WRITE, 3, 4'd12, 32'sh1234, 0, 0);
        send_word(OP_WRITE, 2, 4'd15, -1, 0, 0);
        send_word(OP_QUERY, 0, 0, 0, 16'sh7FFF, 16'sh7FFF);
        send_word(OP_QUERY, 0, 0, 0, 16'sh8000, 16'sh8000);
        set_far(DEPTH_MAX);
        send_word(OP_QUERY, 0, 0, 0, -3, 7);
        set_far(DEPTH_MIN);
        send_word(OP_QUERY, 0, 0, 0, 1, 1);
        set_far(0);

        items = 0;
        while (items < 1000) begin
            if ($urandom_range(0, 3) == 0) begin
                random_face(2'($urandom_range(0, 3)));
                items += 10;
            end else if ($urandom_range(0, 9) == 0) begin
                send_word(OP_WRITE, 2'($urandom), 4'($urandom), $urandom,
                          16'($urandom), 16'($urandom));
                items++;
            end else begin
                send_word(OP_QUERY, 2'($urandom), 4'($urandom), $urandom,
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) : rnd_coord(250),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) : rnd_coord(250));
                items++;
            end
            if (items % 250 < 3 && $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_far(FAR_RESET);
                    1: set_far(DEPTH_MAX);
                    2: set_far(48'($signed($urandom_range(0, 2000)) - 1000) <<< 16);
                    default: set_far(DEPTH_MIN);
                endcase
            end
            if (items > 850) calm = 1'b1;
        end

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
